// ----- hdl/urlrb_pkg.sv -----
package urlrb_pkg;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP_BYTE = 2'd1,
        CMD_POP_LINE = 2'd2,
        CMD_FLUSH    = 2'd3
    } t_cmd;

    // Payload of one input transfer.
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] rx_byte;
    } t_in;

    // Payload of one result transfer.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       last;
        logic [5:0] line_length;
        logic       no_data;
        logic       dropped;
        logic [5:0] lines_waiting;
    } t_out;

    // Character codes and limits.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [5:0] MAX_KEPT = 6'd63;

    // Step addresses of the control program.
    typedef logic [3:0] t_step;
    localparam t_step ST_DISP       = 4'd0;
    localparam t_step ST_PUSH_WR    = 4'd1;
    localparam t_step ST_PUSH_FIN   = 4'd2;
    localparam t_step ST_POPB_CHK   = 4'd3;
    localparam t_step ST_POPB_FIN   = 4'd4;
    localparam t_step ST_POPL_CHK   = 4'd5;
    localparam t_step ST_POPL_CHAR  = 4'd6;
    localparam t_step ST_POPL_CLOSE = 4'd7;
    localparam t_step ST_FLUSH      = 4'd8;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_ACCEPT     = 4'd1,
        OP_PUSH_WR    = 4'd2,
        OP_PUSH_FIN   = 4'd3,
        OP_POPB_CHK   = 4'd4,
        OP_POPB_FIN   = 4'd5,
        OP_POPL_CHK   = 4'd6,
        OP_POPL_CHAR  = 4'd7,
        OP_POPL_CLOSE = 4'd8,
        OP_FLUSH      = 4'd9
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_CMD      = 3'd1,
        COND_EMPTY    = 3'd2,
        COND_NO_LINE  = 3'd3,
        COND_LINE_END = 3'd4
    } t_cond;

    // One control word.
    typedef struct packed {
        t_op   op;
        logic  need_in;
        logic  need_slot;
        t_cond cond;
        t_step next_t;
        t_step next_f;
    } t_cw;

    // Status returned by the datapath for conditional jumps.
    typedef struct packed {
        logic empty;
        logic no_line;
        logic line_end;
    } t_flags;

    // Control handed to the datapath each cycle.
    typedef struct packed {
        logic fire;
        t_op  op;
    } t_ctrl;

    // Control program in read-only form.
    function automatic t_cw ucode(input t_step step);
        t_cw cw;
        case (step)
            ST_DISP: begin
                cw = '{op: OP_ACCEPT, need_in: 1'b1, need_slot: 1'b0, cond: COND_CMD,
                       next_t: ST_DISP, next_f: ST_DISP};
            end
            ST_PUSH_WR: begin
                cw = '{op: OP_PUSH_WR, need_in: 1'b0, need_slot: 1'b0, cond: COND_ALWAYS,
                       next_t: ST_PUSH_FIN, next_f: ST_PUSH_FIN};
            end
            ST_PUSH_FIN: begin
                cw = '{op: OP_PUSH_FIN, need_in: 1'b0, need_slot: 1'b1, cond: COND_ALWAYS,
                       next_t: ST_DISP, next_f: ST_DISP};
            end
            ST_POPB_CHK: begin
                cw = '{op: OP_POPB_CHK, need_in: 1'b0, need_slot: 1'b1, cond: COND_EMPTY,
                       next_t: ST_DISP, next_f: ST_POPB_FIN};
            end
            ST_POPB_FIN: begin
                cw = '{op: OP_POPB_FIN, need_in: 1'b0, need_slot: 1'b1, cond: COND_ALWAYS,
                       next_t: ST_DISP, next_f: ST_DISP};
            end
            ST_POPL_CHK: begin
                cw = '{op: OP_POPL_CHK, need_in: 1'b0, need_slot: 1'b1, cond: COND_NO_LINE,
                       next_t: ST_DISP, next_f: ST_POPL_CHAR};
            end
            ST_POPL_CHAR: begin
                cw = '{op: OP_POPL_CHAR, need_in: 1'b0, need_slot: 1'b1,
                       cond: COND_LINE_END, next_t: ST_POPL_CLOSE, next_f: ST_POPL_CHAR};
            end
            ST_POPL_CLOSE: begin
                cw = '{op: OP_POPL_CLOSE, need_in: 1'b0, need_slot: 1'b1,
                       cond: COND_ALWAYS, next_t: ST_DISP, next_f: ST_DISP};
            end
            ST_FLUSH: begin
                cw = '{op: OP_FLUSH, need_in: 1'b0, need_slot: 1'b1, cond: COND_ALWAYS,
                       next_t: ST_DISP, next_f: ST_DISP};
            end
            default: begin
                cw = '{op: OP_NOP, need_in: 1'b0, need_slot: 1'b0, cond: COND_ALWAYS,
                       next_t: ST_DISP, next_f: ST_DISP};
            end
        endcase
        return cw;
    endfunction

    // Entry step of each command's routine.
    function automatic t_step entry(input t_cmd cmd);
        t_step step;
        case (cmd)
            CMD_PUSH:     step = ST_PUSH_WR;
            CMD_POP_BYTE: step = ST_POPB_CHK;
            CMD_POP_LINE: step = ST_POPL_CHK;
            CMD_FLUSH:    step = ST_FLUSH;
            default:      step = ST_DISP;
        endcase
        return step;
    endfunction

endpackage

// ----- hdl/uart_rx_line_ring_buffer_unit.sv -----
// Each command is taken in the dispatch step and then runs its routine: push writes and finishes,
// pop-byte reads the ring and finishes, flush and a pop that finds no data emit from their first
// step, and pop-line checks, consumes one byte per step and closes. A new command is taken only
// in the dispatch step, and a step that emits waits while a stalled result holds the output.
// Reset clears the step counter, pointers, line count and output valid; the ring
// contents are not cleared and need no clearing pass.
module uart_rx_line_ring_buffer_unit #(
    parameter int RING_DEPTH = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  urlrb_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output urlrb_pkg::t_out o_data
);
    import urlrb_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;
    logic   slot_free;

    // Control program sequencer.
    urlrb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cmd      (i_data.cmd),
        .i_slot_free(slot_free),
        .i_flags    (flags),
        .o_stall    (o_stall),
        .o_ctrl     (ctrl)
    );

    // Ring datapath and output register.
    urlrb_dp #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_ctrl     (ctrl),
        .i_stall    (i_stall),
        .o_slot_free(slot_free),
        .o_flags    (flags),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

endmodule

// ----- hdl/urlrb_seq.sv -----
module urlrb_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  urlrb_pkg::t_cmd  i_cmd,
    input  logic             i_slot_free,
    input  urlrb_pkg::t_flags i_flags,
    output logic             o_stall,
    output urlrb_pkg::t_ctrl o_ctrl
);
    import urlrb_pkg::*;

    t_step r_step;
    t_step n_step;
    t_cw   cw;
    logic  fire;

    // Fetch the control word of the current step.
    assign cw = ucode(r_step);

    // A step runs once its input and output needs are met.
    assign fire    = (!cw.need_slot || i_slot_free) && (!cw.need_in || i_valid);
    assign o_stall = !cw.need_in;
    assign o_ctrl  = '{fire: fire, op: cw.op};

    // Select the next step.
    always_comb begin
        case (cw.cond)
            COND_ALWAYS:   n_step = cw.next_t;
            COND_CMD:      n_step = entry(i_cmd);
            COND_EMPTY:    n_step = i_flags.empty ? cw.next_t : cw.next_f;
            COND_NO_LINE:  n_step = i_flags.no_line ? cw.next_t : cw.next_f;
            COND_LINE_END: n_step = i_flags.line_end ? cw.next_t : cw.next_f;
            default:       n_step = ST_DISP;
        endcase
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_DISP;
        end else if (fire) begin
            r_step <= n_step;
        end
    end

endmodule

// ----- hdl/urlrb_dp.sv -----
module urlrb_dp #(
    parameter int RING_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  urlrb_pkg::t_in    i_data,
    input  urlrb_pkg::t_ctrl  i_ctrl,
    input  logic              i_stall,
    output logic              o_slot_free,
    output urlrb_pkg::t_flags o_flags,
    output logic              o_valid,
    output urlrb_pkg::t_out   o_data
);
    import urlrb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);

    logic [7:0]    r_mem [RING_DEPTH];
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [AW-1:0] rd_addr, rp_adv, wp_adv;
    logic [CW-1:0] r_count, n_count, wait_cnt;
    logic [7:0]    r_rx, n_rx, r_rd;
    logic [5:0]    r_kept, n_kept;
    logic          mem_we, mem_re, emit;
    logic [31:0]   cnt_wide;
    t_out          r_out, n_out;
    logic          r_out_valid;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign rp_adv = adv(r_rp);
    assign wp_adv = adv(r_wp);

    // Status for the sequencer's jumps.
    assign o_flags.empty    = (r_rp == r_wp);
    assign o_flags.no_line  = (r_count == '0);
    assign o_flags.line_end = (r_rd == CH_LF) || (rp_adv == r_wp);

    assign o_slot_free = !r_out_valid || !i_stall;

    // Operation decode: pointer, count and result updates.
    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_count  = r_count;
        n_rx     = r_rx;
        n_kept   = r_kept;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        rd_addr  = r_rp;
        emit     = 1'b0;
        n_out    = '0;
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_ACCEPT: begin
                    n_rx = i_data.rx_byte;
                end
                OP_PUSH_WR: begin
                    mem_we = 1'b1;
                    mem_re = 1'b1;
                    n_wp   = wp_adv;
                    if (r_rx == CH_LF) begin
                        n_count = r_count + 1'b1;
                    end
                end
                OP_PUSH_FIN: begin
                    emit       = 1'b1;
                    n_out.last = 1'b1;
                    // A full ring loses its oldest byte.
                    if (r_wp == r_rp) begin
                        n_out.dropped = 1'b1;
                        n_rp          = rp_adv;
                        if (r_rd == CH_LF && r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                OP_POPB_CHK: begin
                    if (r_rp == r_wp) begin
                        emit          = 1'b1;
                        n_out.last    = 1'b1;
                        n_out.no_data = 1'b1;
                    end else begin
                        mem_re = 1'b1;
                    end
                end
                OP_POPB_FIN: begin
                    emit             = 1'b1;
                    n_out.last       = 1'b1;
                    n_out.byte_out   = r_rd;
                    n_out.byte_valid = 1'b1;
                    n_rp             = rp_adv;
                    if (r_rd == CH_LF && r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                OP_POPL_CHK: begin
                    if (r_count == '0) begin
                        emit          = 1'b1;
                        n_out.last    = 1'b1;
                        n_out.no_data = 1'b1;
                    end else begin
                        mem_re = 1'b1;
                        n_kept = '0;
                    end
                end
                OP_POPL_CHAR: begin
                    // Consume one byte and prefetch the following one.
                    n_rp    = rp_adv;
                    mem_re  = 1'b1;
                    rd_addr = rp_adv;
                    if (r_rd == CH_LF) begin
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end else if (r_rd != CH_CR && r_kept != MAX_KEPT) begin
                        emit             = 1'b1;
                        n_out.byte_out   = r_rd;
                        n_out.byte_valid = 1'b1;
                        n_kept           = r_kept + 1'b1;
                    end
                end
                OP_POPL_CLOSE: begin
                    emit              = 1'b1;
                    n_out.last        = 1'b1;
                    n_out.line_length = r_kept;
                end
                OP_FLUSH: begin
                    emit       = 1'b1;
                    n_out.last = 1'b1;
                    n_rp       = r_wp;
                    n_count    = '0;
                end
                default: begin
                end
            endcase
        end
        // Every result of a pop-line reports the count with the popped line already gone.
        wait_cnt = n_count;
        if (i_ctrl.fire && i_ctrl.op == OP_POPL_CHAR && r_count != '0) begin
            wait_cnt = r_count - 1'b1;
        end
        cnt_wide            = 32'(wait_cnt);
        n_out.lines_waiting = (cnt_wide > 32'd63) ? 6'd63 : cnt_wide[5:0];
    end

    // Ring storage with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= r_rx;
        end
        if (mem_re) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Pointers and line count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Working registers without reset.
    always_ff @(posedge i_clk) begin
        r_rx   <= n_rx;
        r_kept <= n_kept;
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Output register: holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_stall))
        else $error("result overwritten while stalled");

    // Flush leaves an empty ring with no lines.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.fire && i_ctrl.op == OP_FLUSH) |=> (r_rp == r_wp) && (r_count == '0))
        else $error("flush did not empty the ring");

    // Only line characters appear before the closing result.
    a_mid_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> (r_out.byte_valid && !r_out.no_data))
        else $error("non-final result without a byte");

    // An empty pop closes the item and carries no byte.
    a_no_data_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.no_data) |-> (r_out.last && !r_out.byte_valid))
        else $error("no-data result malformed");

endmodule
